@@ hdl/four_channel_incremental_pid_assert.svh @@
// assertion macros for the four channel incremental pid block
`ifndef FOUR_CHANNEL_INCREMENTAL_PID_ASSERT_SVH
`define FOUR_CHANNEL_INCREMENTAL_PID_ASSERT_SVH
`ifndef ASSERT_OFF
// checked while out of reset
`define FCP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("fcipid assertion failed");
// checked on every edge, reset included
`define FCP_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("fcipid reset assertion failed");
`else
`define FCP_ASSERT(label, prop)
`define FCP_ASSERT_RST(label, prop)
`endif
`endif

@@ hdl/fcipid_pkg.sv @@
// shared widths, constants, register codes and helpers of the incremental pid block
package fcipid_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int WHEELS       = 4;
   localparam int GAIN_FRAC    = 8;

   localparam int COUNT_W    = 16;
   localparam int GAIN_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int TOTAL_W    = 32;
   localparam int DRIVE_W    = 11;

   localparam int ERR_W  = COUNT_W + 1;
   // wide enough for e - 2*e1 + e2
   localparam int DE_W   = ERR_W + 2;
   localparam int PROD_W = GAIN_W + 1 + DE_W;
   localparam int ACC_W  = DRIVE_W + GAIN_FRAC;
   // three products plus the accumulator
   localparam int SUM_W  = PROD_W + 3;

   localparam int DRIVE_LIMIT = 1000;
   localparam logic signed [ACC_W-1:0] ACC_LIMIT = ACC_W'(DRIVE_LIMIT << GAIN_FRAC);
   localparam logic signed [SUM_W-1:0] SUM_LIMIT = SUM_W'(ACC_LIMIT);

   localparam logic [GAIN_W-1:0] GAIN_P_RESET = GAIN_W'(3840);
   localparam logic [GAIN_W-1:0] GAIN_I_RESET = GAIN_W'(512);
   localparam logic [GAIN_W-1:0] GAIN_D_RESET = GAIN_W'(128);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P   = 3'd0,
      CSR_GAIN_I   = 3'd1,
      CSR_GAIN_D   = 3'd2,
      CSR_TARGET_A = 3'd3,
      CSR_TARGET_B = 3'd4,
      CSR_TARGET_C = 3'd5,
      CSR_TARGET_D = 3'd6
   } csr_index_type;

   typedef logic signed [COUNT_W-1:0] count_type;
   typedef logic signed [ERR_W-1:0]   err_type;
   typedef logic signed [DE_W-1:0]    diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [DRIVE_W-1:0] drive_type;

   // integer part of the accumulator, rounded toward zero
   function automatic drive_type drive_of(input acc_type acc);
      logic signed [ACC_W:0] biased;
      logic signed [ACC_W:0] shifted;
      biased  = {acc[ACC_W-1], acc}
              + (acc[ACC_W-1] ? (ACC_W+1)'((1 << GAIN_FRAC) - 1) : (ACC_W+1)'(0));
      shifted = biased >>> GAIN_FRAC;
      return shifted[DRIVE_W-1:0];
   endfunction

endpackage

@@ hdl/four_channel_incremental_pid.sv @@
// four wheel incremental pid speed controller with a wheel a count total
//
// channel  dir  handshake          word
// req      in   req_valid/ready    four encoder counts, one control tick
// rsp      out  rsp_valid/ready    four clamped drives and wheel a running total
// csr      in   csr_we             gain and target register write, no read-back
//
// one tick per cycle sustained while rsp is ready; a tick's word reaches rsp through
// the input register, then pid multiply-add-clamp into the result register
// reset clears gains to their defaults, targets, error history and accumulators
// a stalled rsp holds its word while the input register still takes one more tick
`include "four_channel_incremental_pid_assert.svh"

module four_channel_incremental_pid (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [fcipid_pkg::COUNT_W-1:0] req_encoder_a,
   input  logic signed [fcipid_pkg::COUNT_W-1:0] req_encoder_b,
   input  logic signed [fcipid_pkg::COUNT_W-1:0] req_encoder_c,
   input  logic signed [fcipid_pkg::COUNT_W-1:0] req_encoder_d,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [fcipid_pkg::DRIVE_W-1:0] rsp_drive_a,
   output logic signed [fcipid_pkg::DRIVE_W-1:0] rsp_drive_b,
   output logic signed [fcipid_pkg::DRIVE_W-1:0] rsp_drive_c,
   output logic signed [fcipid_pkg::DRIVE_W-1:0] rsp_drive_d,
   output logic signed [fcipid_pkg::TOTAL_W-1:0] rsp_pulse_total_a,
   input  logic                               csr_we,
   input  logic [fcipid_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fcipid_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fcipid_pkg::*;

   // configuration
   logic [GAIN_W-1:0] gain_p_ff;
   logic [GAIN_W-1:0] gain_i_ff;
   logic [GAIN_W-1:0] gain_d_ff;
   count_type         target_ff [NUM_CHANNELS];

   // input register
   logic      s1_valid_ff;
   logic      s1_valid_in;
   count_type enc_ff [NUM_CHANNELS];
   count_type enc_in [NUM_CHANNELS];

   // controller state
   err_type              err1_ff [NUM_CHANNELS];
   err_type              err2_ff [NUM_CHANNELS];
   acc_type              acc_ff      [NUM_CHANNELS];
   logic [TOTAL_W-1:0]   sum_ff;
   err_type              err1_in [NUM_CHANNELS];
   err_type              err2_in [NUM_CHANNELS];
   acc_type              acc_in      [NUM_CHANNELS];
   logic [TOTAL_W-1:0]   sum_in;

   // result register
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   drive_type drive_ff [NUM_CHANNELS];
   drive_type drive_in [NUM_CHANNELS];

   logic out_free;
   logic s1_move;
   logic acc_ok;

   err_type             err   [NUM_CHANNELS];
   diff_type            de    [NUM_CHANNELS];
   diff_type            d2    [NUM_CHANNELS];
   prod_type            prod_p [NUM_CHANNELS];
   prod_type            prod_i [NUM_CHANNELS];
   prod_type            prod_d [NUM_CHANNELS];
   sum_type             total [NUM_CHANNELS];
   logic signed [GAIN_W:0] gp;
   logic signed [GAIN_W:0] gi;
   logic signed [GAIN_W:0] gd;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign s1_move     = s1_valid_ff && out_free;
   assign req_ready   = !s1_valid_ff || out_free;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   assign enc_in[0] = req_encoder_a;
   assign enc_in[1] = req_encoder_b;
   assign enc_in[2] = req_encoder_c;
   assign enc_in[3] = req_encoder_d;

   assign gp = {1'b0, gain_p_ff};
   assign gi = {1'b0, gain_i_ff};
   assign gd = {1'b0, gain_d_ff};

   assign sum_in = sum_ff + TOTAL_W'(enc_ff[0]);

   always_comb begin
      for (int w = 0; w < NUM_CHANNELS; w++) begin
         err[w] = {target_ff[w][COUNT_W-1], target_ff[w]} - {enc_ff[w][COUNT_W-1], enc_ff[w]};
         de[w]  = DE_W'(err[w]) - DE_W'(err1_ff[w]);
         d2[w]  = DE_W'(err[w]) - (DE_W'(err1_ff[w]) <<< 1) + DE_W'(err2_ff[w]);
         prod_p[w] = gp * de[w];
         prod_i[w] = gi * DE_W'(err[w]);
         prod_d[w] = gd * d2[w];
         total[w]  = SUM_W'(acc_ff[w]) + SUM_W'(prod_p[w]) + SUM_W'(prod_i[w])
                   + SUM_W'(prod_d[w]);
         if (w < WHEELS) begin
            if (total[w] > SUM_LIMIT) begin
               acc_in[w] = ACC_LIMIT;
            end else if (total[w] < -SUM_LIMIT) begin
               acc_in[w] = -ACC_LIMIT;
            end else begin
               acc_in[w] = total[w][ACC_W-1:0];
            end
            err1_in[w]  = err[w];
            err2_in[w]  = err1_ff[w];
            drive_in[w] = drive_of(acc_in[w]);
         end else begin
            // unserved wheel keeps its state and drives nothing
            acc_in[w]   = acc_ff[w];
            err1_in[w]  = err1_ff[w];
            err2_in[w]  = err2_ff[w];
            drive_in[w] = '0;
         end
      end
   end

   always_comb begin
      acc_ok = 1'b1;
      for (int w = 0; w < NUM_CHANNELS; w++) begin
         if (acc_ff[w] > ACC_LIMIT || acc_ff[w] < -ACC_LIMIT) begin
            acc_ok = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gain_p_ff    <= GAIN_P_RESET;
         gain_i_ff    <= GAIN_I_RESET;
         gain_d_ff    <= GAIN_D_RESET;
         sum_ff       <= '0;
         for (int w = 0; w < NUM_CHANNELS; w++) begin
            target_ff[w] <= '0;
            err1_ff[w]   <= '0;
            err2_ff[w]   <= '0;
            acc_ff[w]    <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN_P:   gain_p_ff    <= csr_wdata;
               CSR_GAIN_I:   gain_i_ff    <= csr_wdata;
               CSR_GAIN_D:   gain_d_ff    <= csr_wdata;
               CSR_TARGET_A: target_ff[0] <= csr_wdata;
               CSR_TARGET_B: target_ff[1] <= csr_wdata;
               CSR_TARGET_C: target_ff[2] <= csr_wdata;
               CSR_TARGET_D: target_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
         if (s1_move) begin
            sum_ff <= sum_in;
            for (int w = 0; w < NUM_CHANNELS; w++) begin
               err1_ff[w] <= err1_in[w];
               err2_ff[w] <= err2_in[w];
               acc_ff[w]  <= acc_in[w];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         for (int w = 0; w < NUM_CHANNELS; w++) begin
            enc_ff[w] <= enc_in[w];
         end
      end
      if (s1_move) begin
         rsp_pulse_total_a <= sum_in;
         for (int w = 0; w < NUM_CHANNELS; w++) begin
            drive_ff[w] <= drive_in[w];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive_a = drive_ff[0];
   assign rsp_drive_b = drive_ff[1];
   assign rsp_drive_c = drive_ff[2];
   assign rsp_drive_d = drive_ff[3];

   // a tick held in the input register waits for the result register
   `FCP_ASSERT(a_in_hold, s1_valid_ff && !out_free |=> s1_valid_ff)
   // accumulators never leave the clamp range
   `FCP_ASSERT(a_acc_bound, acc_ok)
   // wheel a error history shifts by one on every tick
   `FCP_ASSERT(a_hist_shift, s1_move |=> err2_ff[0] == $past(err1_ff[0]))
   // reset leaves both stages empty
   `FCP_ASSERT_RST(a_reset_empty, reset |=> !s1_valid_ff && !rsp_valid_ff)

endmodule
